// ----- sv/ntfs_fix_pkg.sv -----
// Shared types, constants and helpers for the NTFS record fixup checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package ntfs_fix_pkg;

  localparam int MAX_ARRAY_ENTRIES = 16;
  localparam int ENTRY_IDX_W       = $clog2(MAX_ARRAY_ENTRIES);
  localparam int ENTRY_CNT_W       = $clog2(MAX_ARRAY_ENTRIES + 1);
  localparam int MAX_RECORD_BYTES  = 4096;
  localparam int POS_W             = 12;
  localparam int CFG_W             = 13;
  localparam int SIZE_MIN          = 256;
  localparam int SECTOR_MAX        = 4096;

  localparam logic [CFG_W-1:0] SECTOR_SIZE_RESET = 13'd512;
  localparam logic [CFG_W-1:0] RECORD_SIZE_RESET = 13'd1024;

  localparam logic REG_SECTOR_SIZE = 1'b0;
  localparam logic REG_RECORD_SIZE = 1'b1;

  localparam logic [7:0] IN_USE_FLAG = 8'h01;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FIXUP      = 3'd1,
    ST_SIGNATURE  = 3'd2,
    ST_NOT_IN_USE = 3'd3,
    ST_NUMBER     = 3'd4,
    ST_LAYOUT     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [47:0] expected_record;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_record;
    status_t    status;
  } rsp_t;

  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] addr;
    logic                   high;
    logic [7:0]             wdata;
  } entry_wr_t;

  function automatic logic [7:0] file_magic(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = 8'h46;
      2'd1: m = 8'h49;
      2'd2: m = 8'h4C;
      2'd3: m = 8'h45;
      default: m = 8'h46;
    endcase
    return m;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(SIZE_MIN)) begin
      r = CFG_W'(SIZE_MIN);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ntfs_fix_entry_store.sv -----
// Update sequence array entry store: byte-wide writes, one indexed read port.
// Depends on ntfs_fix_pkg for the entry count and write port struct.
`default_nettype none

module ntfs_fix_entry_store
  import ntfs_fix_pkg::*;
(
  input  wire logic                   clk,
  input  wire entry_wr_t              wr,
  input  wire logic [ENTRY_IDX_W-1:0] rd_addr,
  output logic [15:0]                 rd_data,
  output logic [7:0]                  entry0_low
);

  logic [15:0] entries [MAX_ARRAY_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.high) begin
        entries[wr.addr][15:8] <= wr.wdata;
      end else begin
        entries[wr.addr][7:0] <= wr.wdata;
      end
    end
  end

  assign rd_data    = entries[rd_addr];
  assign entry0_low = entries[0][7:0];

endmodule

`default_nettype wire

// ----- sv/ntfs_fix_engine.sv -----
// Per-byte record engine: header capture, fixup check and substitution, status.
// Depends on ntfs_fix_pkg and ntfs_fix_entry_store.
`default_nettype none

module ntfs_fix_engine
  import ntfs_fix_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire req_t             req,
  input  wire logic [CFG_W-1:0] sector_size,
  input  wire logic [CFG_W-1:0] record_size,
  output rsp_t                  rsp
);

  logic [POS_W-1:0]       byte_position, byte_position_next;
  logic [POS_W-1:0]       sector_offset, sector_offset_next;
  logic [4:0]             sector_index, sector_index_next;
  logic [15:0]            array_offset, array_offset_next;
  logic [15:0]            array_count, array_count_next;
  logic [15:0]            sequence_number, sequence_number_next;
  logic [ENTRY_CNT_W-1:0] entries_received, entries_received_next;
  logic [47:0]            held_expected, held_expected_next;
  logic [31:0]            found_number, found_number_next;
  logic                   signature_good, signature_good_next;
  logic                   in_use_bit, in_use_bit_next;
  logic                   fixup_failed, fixup_failed_next;
  logic                   layout_failed, layout_failed_next;

  entry_wr_t              ent_wr;
  logic [ENTRY_IDX_W-1:0] ent_rd_addr;
  logic [15:0]            ent_rd_data;
  logic [7:0]             entry0_low;

  logic             first;
  logic [CFG_W-1:0] ss, rs;
  logic [POS_W-1:0] ss_m1, ss_m2, rs_m1, pos, so, d;
  logic [5:0]       chk_idx;
  logic             high, last, want_match;
  logic [7:0]       b, want;
  logic [10:0]      k;
  logic [28:0]      span;

  ntfs_fix_entry_store u_store (
    .clk        (clk),
    .wr         (ent_wr),
    .rd_addr    (ent_rd_addr),
    .rd_data    (ent_rd_data),
    .entry0_low (entry0_low)
  );

  always_comb begin
    ss    = clamp_size(sector_size, CFG_W'(SECTOR_MAX));
    rs    = clamp_size(record_size, CFG_W'(MAX_RECORD_BYTES));
    ss_m1 = POS_W'(ss - CFG_W'(1));
    ss_m2 = POS_W'(ss - CFG_W'(2));
    rs_m1 = POS_W'(rs - CFG_W'(1));
    b     = req.data_byte;
    pos   = byte_position;
    first = (byte_position == '0);

    so                    = first ? '0 : sector_offset;
    sector_index_next     = first ? '0 : sector_index;
    entries_received_next = first ? '0 : entries_received;
    sequence_number_next  = first ? '0 : sequence_number;
    found_number_next     = first ? '0 : found_number;
    signature_good_next   = first ? 1'b1 : signature_good;
    in_use_bit_next       = first ? 1'b0 : in_use_bit;
    fixup_failed_next     = first ? 1'b0 : fixup_failed;
    layout_failed_next    = first ? 1'b0 : layout_failed;
    held_expected_next    = first ? req.expected_record : held_expected;
    array_offset_next     = array_offset;
    array_count_next      = array_count;

    rsp.out_byte      = b;
    rsp.end_of_record = 1'b0;
    rsp.status        = ST_OK;

    // check point on the last two bytes of a sector
    chk_idx     = {1'b0, sector_index_next} + 6'd1;
    high        = (so == ss_m1);
    ent_rd_addr = chk_idx[ENTRY_IDX_W-1:0];
    want        = high ? sequence_number_next[15:8] : sequence_number_next[7:0];
    want_match  = (b == want);
    if ((so == ss_m2 || high) && (16'(chk_idx) < array_count)) begin
      if (6'(entries_received_next) > chk_idx) begin
        if (!want_match) begin
          fixup_failed_next = 1'b1;
        end
        rsp.out_byte = high ? ent_rd_data[15:8] : ent_rd_data[7:0];
      end else begin
        layout_failed_next = 1'b1;
      end
    end

    // header fields
    if (pos < POS_W'(4) && b != file_magic(pos[1:0])) begin
      signature_good_next = 1'b0;
    end
    if (pos == POS_W'(4)) array_offset_next = {8'h00, b};
    if (pos == POS_W'(5)) array_offset_next = {b, array_offset[7:0]};
    if (pos == POS_W'(6)) array_count_next  = {8'h00, b};
    if (pos == POS_W'(7)) array_count_next  = {b, array_count[7:0]};
    if (pos == POS_W'(22)) in_use_bit_next  = |(b & IN_USE_FLAG);
    if (pos == POS_W'(44)) found_number_next[7:0]   = b;
    if (pos == POS_W'(45)) found_number_next[15:8]  = b;
    if (pos == POS_W'(46)) found_number_next[23:16] = b;
    if (pos == POS_W'(47)) found_number_next[31:24] = b;

    // array capture
    d            = pos - array_offset[POS_W-1:0];
    k            = d[POS_W-1:1];
    ent_wr.en    = 1'b0;
    ent_wr.addr  = k[ENTRY_IDX_W-1:0];
    ent_wr.high  = d[0];
    ent_wr.wdata = b;
    if (pos >= POS_W'(8) && 16'(pos) >= array_offset &&
        16'(k) < array_count && k < 11'(MAX_ARRAY_ENTRIES)) begin
      ent_wr.en = 1'b1;
      if (d[0] && pos >= POS_W'(9) && k == 11'(entries_received_next)) begin
        entries_received_next = ENTRY_CNT_W'(k) + ENTRY_CNT_W'(1);
        if (k == '0) begin
          sequence_number_next = {b, entry0_low};
        end
      end
    end

    // sector counters
    if (so >= ss_m1) begin
      sector_offset_next = '0;
      if (sector_index_next != 5'd31) begin
        sector_index_next = sector_index_next + 5'd1;
      end
    end else begin
      sector_offset_next = so + POS_W'(1);
    end

    // record end
    span = 29'(array_count - 16'd1) * 29'(ss);
    last = (pos >= rs_m1);
    if (last) begin
      if (array_count > 16'd1 && span > 29'(rs)) begin
        layout_failed_next = 1'b1;
      end
      rsp.end_of_record = 1'b1;
      priority if (layout_failed_next) begin
        rsp.status = ST_LAYOUT;
      end else if (fixup_failed_next) begin
        rsp.status = ST_FIXUP;
      end else if (!signature_good_next) begin
        rsp.status = ST_SIGNATURE;
      end else if (!in_use_bit_next) begin
        rsp.status = ST_NOT_IN_USE;
      end else if (held_expected_next[47:32] != '0 ||
                   held_expected_next[31:0] != found_number_next) begin
        rsp.status = ST_NUMBER;
      end else begin
        rsp.status = ST_OK;
      end
      byte_position_next = '0;
    end else begin
      byte_position_next = pos + POS_W'(1);
    end
    ent_wr.en = ent_wr.en & step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      sector_offset    <= '0;
      sector_index     <= '0;
      array_offset     <= '0;
      array_count      <= '0;
      sequence_number  <= '0;
      entries_received <= '0;
      held_expected    <= '0;
      found_number     <= '0;
      signature_good   <= 1'b1;
      in_use_bit       <= 1'b0;
      fixup_failed     <= 1'b0;
      layout_failed    <= 1'b0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      sector_offset    <= sector_offset_next;
      sector_index     <= sector_index_next;
      array_offset     <= array_offset_next;
      array_count      <= array_count_next;
      sequence_number  <= sequence_number_next;
      entries_received <= entries_received_next;
      held_expected    <= held_expected_next;
      found_number     <= found_number_next;
      signature_good   <= signature_good_next;
      in_use_bit       <= in_use_bit_next;
      fixup_failed     <= fixup_failed_next;
      layout_failed    <= layout_failed_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ntfs_record_fixup_check_core.sv -----
// A byte request is accepted into the input register; the record engine step
// writes its result into the result register. Throughput: one byte per cycle
// while the result register is empty or read; the engine step sets that rate.
// Reset clears both register stages, the record counters and flags, and loads
// sector size 512 and record size 1024. Depends on ntfs_fix_pkg, ntfs_fix_engine.
`default_nettype none

module ntfs_record_fixup_check_core
  import ntfs_fix_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_t             req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_t                  rsp_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic             s1_valid;
  req_t             s1_req;
  logic             advance;
  rsp_t             step_rsp;
  logic [CFG_W-1:0] sector_size, record_size;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size <= SECTOR_SIZE_RESET;
      record_size <= RECORD_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SECTOR_SIZE) begin
        sector_size <= cfg_data;
      end else if (cfg_index == REG_RECORD_SIZE) begin
        record_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req_data;
    end
    if (advance) begin
      rsp_data <= step_rsp;
    end
  end

  ntfs_fix_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .req         (s1_req),
    .sector_size (sector_size),
    .record_size (record_size),
    .rsp         (step_rsp)
  );

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.end_of_record |-> rsp_data.status == ST_OK)
    else $error("status set on a byte that is not the record end");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status <= ST_LAYOUT)
    else $error("status code out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
